// File: rtl/bbr_pkg.sv
package bbr_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;

   // column index into the line stores, row counter runs up to height + 1
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = CSR_INDEX_W'(1);

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(640);
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(480);

   localparam logic OP_PUSH  = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // sum of nine 8-bit taps
   localparam int SUM_W = 12;

   // x / 9 == (x * 7282) >> 16 for every x below 2^15
   localparam int MULT_W      = 13;
   localparam int DIV9_SHIFT  = 16;
   localparam logic [MULT_W-1:0] DIV9_MULT = MULT_W'(7282);

   typedef struct packed {
      logic       operation;
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       frame_last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // one classified item, handed from front to back
   typedef struct packed {
      logic [COL_W-1:0] column;
      pixel_type        pixel;
      logic             emit;
      logic             last;
      logic             mask_left;
      logic             mask_right;
      logic             mask_top;
      logic             mask_bottom;
   } work_type;

   function automatic logic [7:0] div_by_9(input logic [SUM_W-1:0] sum);
      logic [SUM_W+MULT_W-1:0] prod;
      prod = (SUM_W + MULT_W)'(sum) * (SUM_W + MULT_W)'(DIV9_MULT);
      return prod[DIV9_SHIFT +: 8];
   endfunction

endpackage

// File: rtl/bbr_front.sv
module bbr_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  bbr_pkg::req_type                 req_payload,
   input  logic                             csr_write_enable,
   input  logic [bbr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bbr_pkg::CSR_DATA_W-1:0]   csr_data,
   output logic                             restart,
   output logic                             push_valid,
   output bbr_pkg::work_type                push_work,
   input  logic                             push_ready
);
   import bbr_pkg::*;

   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;

   logic [COL_W:0]   width_eff;
   logic [ROW_W-1:0] height_eff;
   logic             pixel_phase;
   logic             drop;
   logic             col_nz;
   logic             col_wrap;
   logic             push;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_data[WIDTH_REG_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_data[HEIGHT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   assign restart = csr_write_enable &&
                    (csr_index == CSR_IMAGE_WIDTH || csr_index == CSR_IMAGE_HEIGHT);

   // zero acts as one, oversize saturates
   always_comb begin
      if (width_ff == '0)
         width_eff = (COL_W + 1)'(1);
      else if (32'(width_ff) > MAX_WIDTH)
         width_eff = (COL_W + 1)'(MAX_WIDTH);
      else
         width_eff = (COL_W + 1)'(width_ff);

      if (height_ff == '0)
         height_eff = ROW_W'(1);
      else if (32'(height_ff) > MAX_HEIGHT)
         height_eff = ROW_W'(MAX_HEIGHT);
      else
         height_eff = ROW_W'(height_ff);
   end

   always_comb begin
      pixel_phase = row_ff < height_eff;
      // a drain while pixels are still expected is swallowed
      drop        = (req_payload.operation == OP_DRAIN) && pixel_phase;
      col_nz      = col_ff != '0;
      col_wrap    = ((COL_W + 1)'(col_ff) + (COL_W + 1)'(1)) >= width_eff;

      push_valid  = req_valid && !drop;
      req_ready   = push_ready;
      push        = push_valid && push_ready;

      push_work.column = col_ff;
      if (pixel_phase) begin
         push_work.pixel.red   = req_payload.in_red;
         push_work.pixel.green = req_payload.in_green;
         push_work.pixel.blue  = req_payload.in_blue;
      end else begin
         push_work.pixel = '0;
      end
      push_work.emit = (col_nz && row_ff >= ROW_W'(1)) || (!col_nz && row_ff >= ROW_W'(2));
      // final result completes on the first column two rows past the last image row
      push_work.last = !col_nz && (row_ff == height_eff + ROW_W'(1));
      // result position is one pixel left and one row up, wrapping at column zero
      push_work.mask_left   = (col_ff == COL_W'(1)) ||
                              (!col_nz && width_eff == (COL_W + 1)'(1));
      push_work.mask_right  = !col_nz;
      push_work.mask_top    = col_nz ? (row_ff == ROW_W'(1)) : (row_ff == ROW_W'(2));
      push_work.mask_bottom = col_nz ? (row_ff == height_eff)
                                     : (row_ff == height_eff + ROW_W'(1));

      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (push) begin
         if (push_work.last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_wrap) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// File: rtl/bbr_queue.sv
module bbr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  bbr_pkg::work_type push_work,
   output logic              head_valid,
   output bbr_pkg::work_type head_work,
   input  logic              pop
);
   import bbr_pkg::*;

   work_type            entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_work  = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      if (pop)
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      if (push && !pop)
         count_in = count_ff + QCNT_W'(1);
      else if (pop && !push)
         count_in = count_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         entries_ff[wr_ptr_ff] <= push_work;
   end

endmodule

// File: rtl/bbr_back.sv
module bbr_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              restart,
   input  logic              head_valid,
   input  bbr_pkg::work_type head_work,
   output logic              head_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bbr_pkg::rsp_type  rsp_payload
);
   import bbr_pkg::*;

   // line stores
   pixel_type older_mem [MAX_WIDTH];
   pixel_type newer_mem [MAX_WIDTH];

   // read stage
   logic      b_valid_ff, b_valid_in;
   work_type  b_work_ff;
   pixel_type older_rd_ff;
   pixel_type newer_rd_ff;

   pixel_type window_ff [6];

   // sum stage
   logic             c_valid_ff, c_valid_in;
   logic             c_last_ff;
   logic [SUM_W-1:0] c_red_ff, c_green_ff, c_blue_ff;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_payload_ff;

   logic             out_free, c_free, c_move, b_move, fwd;
   pixel_type        fresh [3];
   pixel_type        taps [9];
   logic             tap_on [9];
   logic [SUM_W-1:0] red_sum, green_sum, blue_sum;

   always_comb begin
      out_free   = !rsp_valid_ff || rsp_ready;
      c_move     = c_valid_ff && out_free;
      c_free     = !c_valid_ff || out_free;
      b_move     = b_valid_ff && c_free;
      head_pop   = head_valid && (!b_valid_ff || b_move);
      // same column read while the item ahead writes it (width of one, frame wrap)
      fwd        = b_move && (b_work_ff.column == head_work.column);

      b_valid_in = head_pop ? 1'b1 : (b_move ? 1'b0 : b_valid_ff);
      c_valid_in = (b_move && b_work_ff.emit) ? 1'b1 : (c_move ? 1'b0 : c_valid_ff);
      rsp_valid_in = c_move ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (b_move) begin
         older_mem[b_work_ff.column] <= newer_rd_ff;
         newer_mem[b_work_ff.column] <= b_work_ff.pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (head_pop) begin
         b_work_ff <= head_work;
         if (fwd) begin
            older_rd_ff <= newer_rd_ff;
            newer_rd_ff <= b_work_ff.pixel;
         end else begin
            older_rd_ff <= older_mem[head_work.column];
            newer_rd_ff <= newer_mem[head_work.column];
         end
      end
   end

   always_comb begin
      fresh[0] = older_rd_ff;
      fresh[1] = newer_rd_ff;
      fresh[2] = b_work_ff.pixel;
      for (int i = 0; i < 3; i++) begin
         taps[i]     = window_ff[i];
         taps[3 + i] = window_ff[3 + i];
         taps[6 + i] = fresh[i];
      end
      // columns left, center, right; rows above, center, below
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++) begin
            tap_on[k * 3 + i] = !((k == 0 && b_work_ff.mask_left) ||
                                  (k == 2 && b_work_ff.mask_right) ||
                                  (i == 0 && b_work_ff.mask_top) ||
                                  (i == 2 && b_work_ff.mask_bottom));
         end
      end
      red_sum   = '0;
      green_sum = '0;
      blue_sum  = '0;
      for (int t = 0; t < 9; t++) begin
         if (tap_on[t]) begin
            red_sum   = red_sum + SUM_W'(taps[t].red);
            green_sum = green_sum + SUM_W'(taps[t].green);
            blue_sum  = blue_sum + SUM_W'(taps[t].blue);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart || (b_move && b_work_ff.last)) begin
         for (int i = 0; i < 6; i++)
            window_ff[i] <= '0;
      end else if (b_move) begin
         for (int i = 0; i < 3; i++) begin
            window_ff[i]     <= window_ff[3 + i];
            window_ff[3 + i] <= fresh[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b_move && b_work_ff.emit) begin
         c_red_ff   <= red_sum;
         c_green_ff <= green_sum;
         c_blue_ff  <= blue_sum;
         c_last_ff  <= b_work_ff.last;
      end
      if (c_move) begin
         rsp_payload_ff.out_red    <= div_by_9(c_red_ff);
         rsp_payload_ff.out_green  <= div_by_9(c_green_ff);
         rsp_payload_ff.out_blue   <= div_by_9(c_blue_ff);
         rsp_payload_ff.frame_last <= c_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         c_valid_ff   <= c_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// File: rtl/box_blur_3x3_rgb.sv
// Streaming 3x3 box blur of an RGB frame sent in raster order. Each pixel push
// (operation 0) or drain (operation 1) is one transfer; the block takes one
// transfer per clock, sustained, as long as results are taken. Each result
// channel is the sum of the in-image neighbors divided by 9 (truncated, also at
// the borders), and a result trails its pixel by one row plus one pixel. After
// the last pixel of a frame, width + 1 drains (or further pushes, whose pixels
// are ignored) flush the remaining results; frame_last flags the final one and
// the next transfer starts a new frame. A drain sent while pixels are still
// expected is taken and dropped. Writing image_width or image_height restarts
// the frame and must only happen while the block is idle. A classifying front
// end feeds a four-entry queue; the back end reads both 1024-entry line stores
// once and writes them once per queued transfer, sums the window, then divides;
// the queue, read stage, sum stage and output register lie between a transfer
// and its result. The line stores need no clearing after reset.
module box_blur_3x3_rgb (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  bbr_pkg::req_type                 req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output bbr_pkg::rsp_type                 rsp_payload,
   input  logic                             csr_write_enable,
   input  logic [bbr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bbr_pkg::CSR_DATA_W-1:0]   csr_data
);
   import bbr_pkg::*;

   logic     restart;
   logic     push_valid, push_ready;
   work_type push_work;
   logic     head_valid, head_pop;
   work_type head_work;

   bbr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .restart          (restart),
      .push_valid       (push_valid),
      .push_work        (push_work),
      .push_ready       (push_ready)
   );

   bbr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_work  (push_work),
      .head_valid (head_valid),
      .head_work  (head_work),
      .pop        (head_pop)
   );

   bbr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .restart     (restart),
      .head_valid  (head_valid),
      .head_work   (head_work),
      .head_pop    (head_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: verif/tb_box_blur_3x3_rgb.sv
`timescale 1ns / 1ps

import bbr_pkg::*;

class blur_scoreboard;
   pixel_type              older_row [MAX_WIDTH];
   pixel_type              newer_row [MAX_WIDTH];
   pixel_type              window [6];   // 0..2 left column, 3..5 center; top to bottom
   int unsigned            in_col, in_row, out_col, out_row;
   logic [WIDTH_REG_W-1:0] width_reg;
   logic [HEIGHT_REG_W-1:0] height_reg;
   rsp_type                expected_blur [$];
   int unsigned            errors;

   function new();
      foreach (older_row[i]) begin
         older_row[i] = '0;
         newer_row[i] = '0;
      end
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      errors     = 0;
      restart_frame();
   endfunction

   function void restart_frame();
      foreach (window[i]) window[i] = '0;
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
   endfunction

   function int unsigned clamp_size(int unsigned v, int unsigned limit);
      if (v == 0) return 1;
      return (v > limit) ? limit : v;
   endfunction

   function void write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      if (index == CSR_IMAGE_WIDTH) begin
         width_reg = value[WIDTH_REG_W-1:0];
         restart_frame();
      end else if (index == CSR_IMAGE_HEIGHT) begin
         height_reg = value[HEIGHT_REG_W-1:0];
         restart_frame();
      end
   endfunction

   function int unsigned pending();
      return expected_blur.size();
   endfunction

   // advance the raster state by one transfer, queue the blur it completes
   function void note_transfer(req_type item);
      int unsigned w, h, r, c, orow, ocol, sum_r, sum_g, sum_b;
      pixel_type   fresh [3];
      pixel_type   tap;
      bit          emit, is_last;
      rsp_type     result;
      w = clamp_size(width_reg, MAX_WIDTH);
      h = clamp_size(height_reg, MAX_HEIGHT);
      r = in_row;
      c = in_col;
      if (c >= w) c = 0;
      // drain while pixels are still due: dropped
      if (item.operation == OP_DRAIN && r < h) return;
      fresh[0] = older_row[c];
      fresh[1] = newer_row[c];
      fresh[2] = (r < h) ? {item.in_red, item.in_green, item.in_blue} : '0;
      emit = (c >= 1 && r >= 1) || (c == 0 && r >= 2);
      is_last = 1'b0;
      if (emit) begin
         orow  = out_row;
         ocol  = out_col;
         sum_r = 0;
         sum_g = 0;
         sum_b = 0;
         for (int k = 0; k < 3; k++) begin
            if (k == 0 && ocol == 0) continue;
            if (k == 2 && ocol + 1 >= w) continue;
            for (int i = 0; i < 3; i++) begin
               if (i == 0 && orow == 0) continue;
               if (i == 2 && orow + 1 >= h) continue;
               if (k < 2) tap = window[k * 3 + i];
               else tap = (c >= 1) ? fresh[i] : '0;
               sum_r += tap.red;
               sum_g += tap.green;
               sum_b += tap.blue;
            end
         end
         is_last = (orow + 1 >= h) && (ocol + 1 >= w);
         result.out_red    = 8'(sum_r / 9);
         result.out_green  = 8'(sum_g / 9);
         result.out_blue   = 8'(sum_b / 9);
         result.frame_last = is_last;
         expected_blur.push_back(result);
         out_col = ocol + 1;
         if (out_col >= w) begin
            out_col = 0;
            out_row = orow + 1;
         end
      end
      older_row[c] = fresh[1];
      newer_row[c] = fresh[2];
      for (int i = 0; i < 3; i++) begin
         window[i]     = window[3 + i];
         window[3 + i] = fresh[i];
      end
      in_col = c + 1;
      in_row = r;
      if (in_col >= w) begin
         in_col = 0;
         in_row = r + 1;
      end
      if (is_last) restart_frame();
   endfunction

   function void check_result(rsp_type got);
      rsp_type want;
      if (expected_blur.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("unexpected result: rgb %h %h %h last %b",
                     got.out_red, got.out_green, got.out_blue, got.frame_last);
         return;
      end
      want = expected_blur.pop_front();
      if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
          got.out_blue !== want.out_blue || got.frame_last !== want.frame_last) begin
         errors++;
         if (errors <= 10)
            $display("blur mismatch: expected rgb %h %h %h last %b, got rgb %h %h %h last %b",
                     want.out_red, want.out_green, want.out_blue, want.frame_last,
                     got.out_red, got.out_green, got.out_blue, got.frame_last);
      end
   endfunction
endclass

module tb_box_blur_3x3_rgb;
   import bbr_pkg::*;

   localparam int unsigned CLOCK_LIMIT      = 1_000_000;
   localparam int unsigned SETTLE_CYCLES    = 16;
   localparam int unsigned LONG_HOLD_CYCLES = 300;
   localparam int unsigned RANDOM_ITEMS     = 350;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_LOW  = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_HIGH = CSR_INDEX_W'(3);

   localparam pixel_type WHITE = 24'hFFFFFF;
   localparam pixel_type BLACK = 24'h000000;
   localparam pixel_type MIXED = 24'hFF0080;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_payload;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_payload;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   blur_scoreboard board = new();
   int unsigned    cycle_count = 0;
   int unsigned    gap_odds = 0;
   int unsigned    random_items = 0;
   bit             calm = 1'b0;
   bit             hold_request = 1'b0;

   box_blur_3x3_rgb dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CLOCK_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable) board.write_register(csr_index, csr_data);
         if (req_valid && req_ready) board.note_transfer(req_payload);
         if (rsp_valid && rsp_ready) board.check_result(rsp_payload);
      end
   end

   // result side: random stall bursts, plus one long hold-off on request
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) stall_left--;
         else if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = LONG_HOLD_CYCLES;
         end else if (!calm && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 14);
         rsp_ready <= (stall_left == 0);
      end
   end

   function automatic pixel_type random_pixel();
      logic [23:0] bits;
      bits = 24'($urandom);
      return bits;
   endfunction

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send(input logic op, input pixel_type pix);
      int unsigned gap;
      gap = 0;
      if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
         gap = $urandom_range(1, 14);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_payload <= {op, pix.red, pix.green, pix.blue};
      req_valid   <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_index        <= index;
      csr_data         <= value;
      csr_write_enable <= 1'b1;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // all pixels, optional stray drains, then width + 1 flush transfers
   task automatic send_frame(input int unsigned w, input int unsigned h, input bit noisy);
      for (int unsigned n = 0; n < w * h; n++) begin
         if (noisy && $urandom_range(0, 9) == 0) send(OP_DRAIN, random_pixel());
         send(OP_PUSH, random_pixel());
      end
      for (int unsigned n = 0; n <= w; n++)
         send($urandom_range(0, 1) ? OP_DRAIN : OP_PUSH, random_pixel());
   endtask

   // results drained, then time for transfers that yield nothing
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      int unsigned w, h, frames, partial;
      bit          first_phase;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_payload      = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_IMAGE_WIDTH;
      csr_data         = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset size 640 x 480: first rows only
      gap_odds = 6;
      send(OP_DRAIN, random_pixel());
      repeat (660) send(OP_PUSH, random_pixel());
      wait_idle();

      // 3 x 3: full-scale sums, stray drains, late push during flush
      write_csr(CSR_IMAGE_WIDTH, CSR_DATA_W'(3));
      write_csr(CSR_IMAGE_HEIGHT, CSR_DATA_W'(3));
      send(OP_DRAIN, WHITE);
      for (int n = 0; n < 9; n++) begin
         if (n == 4) send(OP_DRAIN, BLACK);
         send(OP_PUSH, (n == 8) ? MIXED : WHITE);
      end
      send(OP_PUSH, WHITE);
      repeat (3) send(OP_DRAIN, BLACK);
      send(OP_DRAIN, WHITE);
      wait_idle();

      // unmapped indexes do nothing; zero sizes act as one
      write_csr(CSR_UNMAPPED_LOW, CSR_DATA_W'($urandom));
      write_csr(CSR_UNMAPPED_HIGH, CSR_DATA_W'($urandom));
      write_csr(CSR_IMAGE_WIDTH, '0);
      write_csr(CSR_IMAGE_HEIGHT, '0);
      send(OP_PUSH, WHITE);
      send(OP_DRAIN, BLACK);
      send(OP_PUSH, WHITE);
      wait_idle();

      first_phase = 1'b1;
      while (random_items < RANDOM_ITEMS) begin
         calm     = (random_items > RANDOM_ITEMS * 3 / 4);
         gap_odds = $urandom_range(0, 1) ? $urandom_range(2, 12) : 0;
         if ($urandom_range(0, 3) == 0)
            write_csr($urandom_range(0, 1) ? CSR_UNMAPPED_LOW : CSR_UNMAPPED_HIGH,
                      CSR_DATA_W'($urandom));
         if (first_phase) begin
            // long result hold-off while the sender keeps going
            w = 8;
            h = 20;
            gap_odds = 0;
            hold_request = 1'b1;
         end else if ($urandom_range(0, 7) == 0) begin
            w = $urandom_range(1, 40);
            h = $urandom_range(1, 12);
         end else begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 8);
         end
         // upper data bits lie outside the width register
         write_csr(CSR_IMAGE_WIDTH, {2'($urandom), WIDTH_REG_W'(w)});
         write_csr(CSR_IMAGE_HEIGHT, CSR_DATA_W'(h));
         frames = first_phase ? 1 : $urandom_range(1, 3);
         first_phase = 1'b0;
         repeat (frames) begin
            send_frame(w, h, 1'b1);
            random_items += w * h + w + 1;
         end
         // abandoned frame, restarted by the next register write
         if (!calm && $urandom_range(0, 5) == 0) begin
            partial = $urandom_range(1, w * h);
            repeat (partial) send(OP_PUSH, random_pixel());
            random_items += partial;
         end
         wait_idle();
      end

      if (board.errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: box_blur_3x3_rgb.f
rtl/bbr_pkg.sv
rtl/bbr_front.sv
rtl/bbr_queue.sv
rtl/bbr_back.sv
rtl/box_blur_3x3_rgb.sv
verif/tb_box_blur_3x3_rgb.sv
